// ----- rtl/fbr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbr_pkg: shared types and constants
// Panel geometry, instruction bytes and the command format that passes from
// the front end to the back end of the two-chip panel frame buffer.
// ----------------------------------------------------------------------------
package fbr_pkg;

	localparam int PANEL_COLUMNS  = 128;
	localparam int PANEL_ROWS     = 64;
	localparam int CHIP_COLUMNS   = 64;

	localparam int PAGE_COUNT     = PANEL_ROWS / 8;
	localparam int PAGE_W         = 3;
	localparam int SLOTS_PER_HALF = CHIP_COLUMNS + 2;
	localparam int SLOT_W         = $clog2(SLOTS_PER_HALF);
	localparam int PCOL_W         = $clog2(PANEL_COLUMNS);
	localparam int COLX_W         = $clog2(2 * CHIP_COLUMNS) + 1;
	localparam int ADDR_W         = PAGE_W + PCOL_W;
	localparam int STORE_DEPTH    = 2 ** ADDR_W;

	localparam int QUEUE_DEPTH    = 4;
	localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] INSTR_SET_PAGE = 8'hB8;
	localparam logic [7:0] INSTR_SET_COL  = 8'h40;
	localparam logic [7:0] INSTR_DISP_ON  = 8'h3F;
	localparam logic [7:0] INSTR_DISP_OFF = 8'h3E;

	typedef enum logic [2:0] {
		ACT_PIXEL = 3'd0,
		ACT_CLEAR = 3'd1,
		ACT_START = 3'd2,
		ACT_TICK  = 3'd3,
		ACT_POWER = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		CMD_PIXEL = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_EMIT  = 2'd2,
		CMD_READ  = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [ADDR_W-1:0] addr;
		logic [2:0]        bit_sel;
		logic              pixel_on;
		logic              col_ok;
		logic              sel_left;
		logic              sel_right;
		logic [7:0]        bus_byte;
		logic              last;
	} cmd_t;

endpackage

// ----- rtl/fbr_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbr_ram: generic single-port RAM
// One read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
module fbr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ----- rtl/fbr_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbr_front: input decoder and refresh scanner
// Accepts input transfers, keeps the scan position and turns each item into
// at most one command for the back end.
// ----------------------------------------------------------------------------
module fbr_front import fbr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [7:0]  pixel_x,
	input  logic [7:0]  pixel_y,
	input  logic        pixel_on,
	input  logic        power_on,
	input  logic        q_full,
	output logic        push,
	output cmd_t        cmd
);

	logic              active_q;
	logic [PAGE_W-1:0] page_q;
	logic              half_q;
	logic [SLOT_W-1:0] slot_q;

	logic              accept;
	logic              has_cmd;
	logic              slot_end;
	logic              page_end;
	logic [COLX_W-1:0] col_x;
	logic              pix_in;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && has_cmd;

	assign slot_end = slot_q == SLOT_W'(SLOTS_PER_HALF - 1);
	assign page_end = page_q == PAGE_W'(PAGE_COUNT - 1);
	assign col_x    = (half_q ? COLX_W'(CHIP_COLUMNS) : COLX_W'(0))
		+ COLX_W'(slot_q - SLOT_W'(2));
	assign pix_in   = ({1'b0, pixel_x} < 9'(PANEL_COLUMNS))
		&& ({1'b0, pixel_y} < 9'(PANEL_ROWS));

	always_comb begin
		has_cmd       = 1'b0;
		cmd           = '0;
		cmd.kind      = CMD_EMIT;
		cmd.sel_left  = !half_q;
		cmd.sel_right = half_q;
		unique case (action_t'(action))
			ACT_PIXEL: begin
				has_cmd      = pix_in;
				cmd.kind     = CMD_PIXEL;
				cmd.addr     = {pixel_y[5:3], pixel_x[PCOL_W-1:0]};
				cmd.bit_sel  = pixel_y[2:0];
				cmd.pixel_on = pixel_on;
			end
			ACT_CLEAR: begin
				has_cmd  = 1'b1;
				cmd.kind = CMD_CLEAR;
			end
			ACT_TICK: begin
				has_cmd = active_q;
				if (slot_q == SLOT_W'(0)) begin
					cmd.bus_byte = INSTR_SET_PAGE | {{(8 - PAGE_W){1'b0}}, page_q};
				end else if (slot_q == SLOT_W'(1)) begin
					cmd.bus_byte = INSTR_SET_COL;
				end else begin
					cmd.kind   = CMD_READ;
					cmd.addr   = {page_q, col_x[PCOL_W-1:0]};
					cmd.col_ok = col_x < COLX_W'(PANEL_COLUMNS);
					cmd.last   = slot_end && half_q && page_end;
				end
			end
			ACT_POWER: begin
				has_cmd       = 1'b1;
				cmd.sel_left  = 1'b1;
				cmd.sel_right = 1'b1;
				cmd.bus_byte  = power_on ? INSTR_DISP_ON : INSTR_DISP_OFF;
			end
			default: begin
				has_cmd = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			page_q   <= '0;
			half_q   <= 1'b0;
			slot_q   <= '0;
		end else if (accept) begin
			if (action_t'(action) == ACT_START) begin
				active_q <= 1'b1;
				page_q   <= '0;
				half_q   <= 1'b0;
				slot_q   <= '0;
			end else if (action_t'(action) == ACT_TICK && active_q) begin
				if (!slot_end) begin
					slot_q <= slot_q + SLOT_W'(1);
				end else begin
					slot_q <= '0;
					half_q <= !half_q;
					if (half_q) begin
						if (page_end) begin
							page_q   <= '0;
							active_q <= 1'b0;
						end else begin
							page_q <= page_q + PAGE_W'(1);
						end
					end
				end
			end
		end
	end

endmodule

// ----- rtl/fbr_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbr_queue: command queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module fbr_queue import fbr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output cmd_t head
);

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full      = count_q == (QPTR_W + 1)'(QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W + 1)'(1);
			end
		end
	end

endmodule

// ----- rtl/fbr_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbr_back: frame store and bus write engine
// Executes queued commands against the frame store and drives the output
// register toward the panel bus.
// ----------------------------------------------------------------------------
module fbr_back import fbr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_not_empty,
	input  cmd_t        q_head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        out_left,
	output logic        out_right,
	output logic        out_is_data,
	output logic [7:0]  out_byte,
	output logic        out_last
);

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_RMW   = 4'b0100,
		ST_READ  = 4'b1000
	} state_t;

	state_t            state_q;
	state_t            state_d;
	logic [ADDR_W-1:0] clr_cnt_q;
	cmd_t              cur_q;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [7:0]        ram_wdata;
	logic [7:0]        ram_rdata;
	logic [7:0]        bit_mask;
	logic              can_out;
	logic              load;
	logic              load_data;
	logic [7:0]        load_byte;

	fbr_ram #(
		.WIDTH(8),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	assign can_out  = !out_valid || out_ready;
	assign bit_mask = 8'(1) << cur_q.bit_sel;

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = q_head.addr;
		ram_wdata = '0;
		load      = 1'b0;
		load_data = 1'b0;
		load_byte = q_head.bus_byte;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we   = 1'b1;
				ram_addr = clr_cnt_q;
				if (clr_cnt_q == ADDR_W'(STORE_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (q_not_empty) begin
					unique case (q_head.kind)
						CMD_PIXEL: begin
							pop     = 1'b1;
							state_d = ST_RMW;
						end
						CMD_CLEAR: begin
							pop     = 1'b1;
							state_d = ST_CLEAR;
						end
						CMD_EMIT: begin
							pop  = can_out;
							load = can_out;
						end
						CMD_READ: begin
							pop = can_out;
							if (can_out) begin
								state_d = ST_READ;
							end
						end
					endcase
				end
			end
			ST_RMW: begin
				ram_we    = 1'b1;
				ram_addr  = cur_q.addr;
				ram_wdata = cur_q.pixel_on ? (ram_rdata | bit_mask)
					: (ram_rdata & ~bit_mask);
				state_d   = ST_IDLE;
			end
			ST_READ: begin
				// output register was freed when the read was issued
				ram_addr  = cur_q.addr;
				load      = 1'b1;
				load_data = 1'b1;
				load_byte = cur_q.col_ok ? ram_rdata : 8'h00;
				state_d   = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
			end else begin
				clr_cnt_q <= '0;
			end
			if (load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_head;
		end
		if (load) begin
			out_left    <= load_data ? cur_q.sel_left : q_head.sel_left;
			out_right   <= load_data ? cur_q.sel_right : q_head.sel_right;
			out_is_data <= load_data;
			out_byte    <= load_byte;
			out_last    <= load_data && cur_q.last;
		end
	end

endmodule

// ----- rtl/dual_chip_glcd_framebuffer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_chip_glcd_framebuffer: two-chip monochrome panel frame buffer
// Page-organized 128x64 pixel store with a refresh scanner that produces
// the panel bus writes for two 64-column driver chips.
// ----------------------------------------------------------------------------
// Input stream: tuser carries the action (pixel write, clear, refresh start,
// bus tick, display power); tdata carries the pixel coordinates and flags.
// Output stream: one transfer per panel bus write; tuser is high for a data
// byte, tlast marks the final data byte of a full refresh.
// Each input item is decoded in the cycle it is taken and queued for the
// back end. With an idle back end, an instruction write (set page, set
// column, power) reaches tvalid through the queue and the output register,
// a data byte through the queue, a store read and the output register.
// Instruction writes leave at one per cycle while the output side is ready;
// data bytes and pixel writes each read, then write or present, through the
// single port of the frame store RAM. A clear writes all 1024 store bytes,
// one per cycle, while the back end takes no command; reset does the same.
// When the output side stalls, the output register holds its transfer and a
// bus write at the head of the queue waits, holding the commands behind it;
// the input side stalls only once the four-entry command queue is full.
// ----------------------------------------------------------------------------
module dual_chip_glcd_framebuffer import fbr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // pixel_x, pixel_y, pixel_on, power_on, zero pad
	input  logic [2:0]  s_axis_tuser,   // action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // select_left, select_right, bus_byte, zero pad
	output logic        m_axis_tuser,   // is_data
	output logic        m_axis_tlast
);

	logic q_full;
	logic q_push;
	cmd_t q_push_cmd;
	logic q_pop;
	logic q_not_empty;
	cmd_t q_head;
	logic out_left;
	logic out_right;
	logic [7:0] out_byte;

	fbr_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.action  (s_axis_tuser),
		.pixel_x (s_axis_tdata[7:0]),
		.pixel_y (s_axis_tdata[15:8]),
		.pixel_on(s_axis_tdata[16]),
		.power_on(s_axis_tdata[17]),
		.q_full  (q_full),
		.push    (q_push),
		.cmd     (q_push_cmd)
	);

	fbr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.not_empty(q_not_empty),
		.head     (q_head)
	);

	fbr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_not_empty(q_not_empty),
		.q_head     (q_head),
		.pop        (q_pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_left   (out_left),
		.out_right  (out_right),
		.out_is_data(m_axis_tuser),
		.out_byte   (out_byte),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {6'b0, out_byte, out_right, out_left};

endmodule

// ----- verif/glcd_bus_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glcd_bus_checker: panel bus write checker
// Watches both stream channels of the two-chip panel frame buffer. It keeps a
// shadow of the page store and of the refresh scanner, predicts the panel
// write that each transfer in causes, and compares every transfer out with
// the oldest pending prediction.
// ----------------------------------------------------------------------------
module glcd_bus_checker import fbr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // pixel_x, pixel_y, pixel_on, power_on, zero pad
	input  logic [2:0]  s_axis_tuser,   // action
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,   // select_left, select_right, bus_byte, zero pad
	input  logic        m_axis_tuser,   // is_data
	input  logic        m_axis_tlast,
	output int          mismatches,
	output int          writes_pending,
	output int          writes_seen,
	output int          refreshes_done,
	output int          pixels_drawn
);

	typedef struct packed {
		logic       sel_left;
		logic       sel_right;
		logic       is_data;
		logic [7:0] bus_byte;
		logic       last;
	} bus_write_t;

	logic [7:0] shadow_store [PAGE_COUNT][PANEL_COLUMNS];
	logic       scan_on;
	logic [2:0] scan_page;
	logic       scan_half;
	logic [6:0] scan_slot;
	bus_write_t expected_writes [$];
	bus_write_t want;
	bus_write_t got;

	task automatic check_field(input string name, input int exp_val, input int act_val);
		if (exp_val != act_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, act_val);
			mismatches++;
		end
	endtask

	// next write of the refresh scan, then step the scan position
	task automatic scan_step();
		bus_write_t w;
		int col;
		w.sel_left  = (scan_half == 1'b0);
		w.sel_right = (scan_half == 1'b1);
		w.last      = 1'b0;
		if (scan_slot == 0) begin
			w.is_data  = 1'b0;
			w.bus_byte = INSTR_SET_PAGE | {5'd0, scan_page};
		end else if (scan_slot == 1) begin
			w.is_data  = 1'b0;
			w.bus_byte = INSTR_SET_COL;
		end else begin
			col        = int'(scan_half) * CHIP_COLUMNS + int'(scan_slot) - 2;
			w.is_data  = 1'b1;
			w.bus_byte = (col < PANEL_COLUMNS) ? shadow_store[scan_page][col] : 8'd0;
			w.last     = (scan_slot == SLOTS_PER_HALF - 1) && scan_half &&
				(scan_page == PAGE_COUNT - 1);
		end
		expected_writes.push_back(w);
		scan_slot++;
		if (scan_slot >= SLOTS_PER_HALF) begin
			scan_slot = '0;
			if (!scan_half) begin
				scan_half = 1'b1;
			end else begin
				scan_half = 1'b0;
				if (scan_page == PAGE_COUNT - 1) begin
					scan_page = '0;
					scan_on   = 1'b0;
				end else begin
					scan_page++;
				end
			end
		end
	endtask

	task automatic apply_action(input logic [2:0] act, input logic [7:0] x, input logic [7:0] y,
			input logic on, input logic pwr);
		bus_write_t w;
		case (act)
			ACT_PIXEL: begin
				if (x < PANEL_COLUMNS && y < PANEL_ROWS) begin
					shadow_store[y / 8][x][y % 8] = on;
					pixels_drawn++;
				end
			end
			ACT_CLEAR: begin
				foreach (shadow_store[p, c])
					shadow_store[p][c] = 8'd0;
			end
			ACT_START: begin
				scan_on   = 1'b1;
				scan_page = '0;
				scan_half = 1'b0;
				scan_slot = '0;
			end
			ACT_TICK: begin
				if (scan_on)
					scan_step();
			end
			ACT_POWER: begin
				w.sel_left  = 1'b1;
				w.sel_right = 1'b1;
				w.is_data   = 1'b0;
				w.bus_byte  = pwr ? INSTR_DISP_ON : INSTR_DISP_OFF;
				w.last      = 1'b0;
				expected_writes.push_back(w);
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (shadow_store[p, c])
				shadow_store[p][c] = 8'd0;
			scan_on   = 1'b0;
			scan_page = '0;
			scan_half = 1'b0;
			scan_slot = '0;
			expected_writes.delete();
			mismatches     = 0;
			writes_pending = 0;
			writes_seen    = 0;
			refreshes_done = 0;
			pixels_drawn   = 0;
		end else begin
			// a transfer in cannot show up at the output on the same edge
			if (m_axis_tvalid && m_axis_tready) begin
				writes_seen++;
				got = {m_axis_tdata[0], m_axis_tdata[1], m_axis_tuser, m_axis_tdata[9:2],
					m_axis_tlast};
				if (got.last)
					refreshes_done++;
				if (expected_writes.size() == 0) begin
					$error("unexpected panel write: tdata %h tuser %b tlast %b",
						m_axis_tdata, m_axis_tuser, m_axis_tlast);
					mismatches++;
				end else begin
					want = expected_writes.pop_front();
					check_field("select_left", want.sel_left, got.sel_left);
					check_field("select_right", want.sel_right, got.sel_right);
					check_field("is_data", want.is_data, got.is_data);
					check_field("bus_byte", want.bus_byte, got.bus_byte);
					check_field("refresh_last", want.last, got.last);
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				apply_action(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8],
					s_axis_tdata[16], s_axis_tdata[17]);
			writes_pending = expected_writes.size();
		end
	end

endmodule

// ----- verif/dual_chip_glcd_framebuffer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_chip_glcd_framebuffer_tb: frame buffer testbench top
// Drives pixel writes, clears, refresh starts, bus ticks and power actions
// into the block with random gaps on both sides, including one long output
// stall, and leaves prediction and comparison to the bus write checker.
// ----------------------------------------------------------------------------
module dual_chip_glcd_framebuffer_tb import fbr_pkg::*;;

	localparam int CYCLE_LIMIT     = 1_000_000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int HOLD_OFF_AT     = 400;
	localparam int DRAIN_CYCLES    = 1100;
	localparam int MIXED_ITEMS     = 600;
	localparam int FULL_SCAN_TICKS = SLOTS_PER_HALF * 2 * PAGE_COUNT;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;
	logic [2:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;

	int mismatches;
	int writes_pending;
	int writes_seen;
	int refreshes_done;
	int pixels_drawn;
	int cycles = 0;
	int items_sent = 0;
	bit sender_burst = 1'b0;

	dual_chip_glcd_framebuffer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	glcd_bus_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tuser   (s_axis_tuser),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tuser   (m_axis_tuser),
		.m_axis_tlast   (m_axis_tlast),
		.mismatches     (mismatches),
		.writes_pending (writes_pending),
		.writes_seen    (writes_seen),
		.refreshes_done (refreshes_done),
		.pixels_drawn   (pixels_drawn)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("dual_chip_glcd_framebuffer_tb: done, errors");
			$finish;
		end
	end

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_item(input logic [2:0] act, input logic [7:0] x, input logic [7:0] y,
			input logic on, input logic pwr);
		int gap;
		if (items_sent % 64 == 0)
			sender_burst = ($urandom_range(0, 3) == 0);
		gap = sender_burst ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'd0, pwr, on, y, x};
		s_axis_tuser  <= act;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	// action with random side fields
	task automatic send_action(input logic [2:0] act);
		send_item(act, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	task automatic send_pixel_in_panel();
		send_item(ACT_PIXEL, 8'($urandom_range(0, PANEL_COLUMNS - 1)),
			8'($urandom_range(0, PANEL_ROWS - 1)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)));
	endtask

	// output side: random per-transfer stalls, one long hold-off
	initial begin
		int gap;
		int taken;
		bit burst;
		m_axis_tready = 1'b0;
		taken = 0;
		burst = 1'b0;
		@(negedge clk);
		forever begin
			if (taken % 50 == 0)
				burst = ($urandom_range(0, 3) == 0);
			gap = burst ? 0 : $urandom_range(0, 18);
			if (taken == HOLD_OFF_AT)
				gap = HOLD_OFF_CYCLES;
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			taken++;
			@(negedge clk);
		end
	end

	initial begin
		int r;
		int ticks_left;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = ACT_PIXEL;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: corners, off-panel pixels, unused codes, scan interactions
		send_item(ACT_TICK, 8'd0, 8'd0, 1'b0, 1'b0);
		send_item(ACT_POWER, 8'd0, 8'd0, 1'b0, 1'b1);
		send_item(ACT_POWER, 8'hFF, 8'hFF, 1'b1, 1'b0);
		send_item(ACT_PIXEL, 8'd0, 8'd0, 1'b1, 1'b0);
		send_item(ACT_PIXEL, 8'd127, 8'd63, 1'b1, 1'b0);
		send_item(ACT_PIXEL, 8'd128, 8'd5, 1'b1, 1'b0);
		send_item(ACT_PIXEL, 8'd5, 8'd64, 1'b1, 1'b0);
		send_item(ACT_PIXEL, 8'd255, 8'd255, 1'b1, 1'b1);
		send_item(ACT_PIXEL, 8'd2, 8'd7, 1'b1, 1'b0);
		send_item(ACT_PIXEL, 8'd0, 8'd0, 1'b0, 1'b0);
		send_action(3'd5);
		send_action(3'd6);
		send_action(3'd7);
		send_item(ACT_START, 8'd0, 8'd0, 1'b0, 1'b0);
		repeat (4) send_item(ACT_TICK, 8'd0, 8'd0, 1'b0, 1'b0);
		// power mid-scan, then a pixel landing just ahead of the scan
		send_item(ACT_POWER, 8'd0, 8'd0, 1'b0, 1'b1);
		send_item(ACT_PIXEL, 8'd3, 8'd1, 1'b1, 1'b0);
		send_item(ACT_TICK, 8'd0, 8'd0, 1'b0, 1'b0);
		send_item(ACT_CLEAR, 8'd0, 8'd0, 1'b0, 1'b0);
		send_item(ACT_TICK, 8'd0, 8'd0, 1'b0, 1'b0);
		// restart while scanning
		send_item(ACT_START, 8'd0, 8'd0, 1'b0, 1'b0);
		repeat (3) send_item(ACT_TICK, 8'd0, 8'd0, 1'b0, 1'b0);

		// mixed traffic with frequent restarts
		repeat (MIXED_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 35)
				send_pixel_in_panel();
			else if (r < 40)
				send_action(ACT_PIXEL);
			else if (r < 75)
				send_action(ACT_TICK);
			else if (r < 80)
				send_action(ACT_START);
			else if (r < 85)
				send_action(ACT_POWER);
			else if (r < 86)
				send_action(ACT_CLEAR);
			else if (r < 90)
				send_action(3'($urandom_range(5, 7)));
			else
				send_action(ACT_TICK);
		end

		// one uninterrupted refresh, drawing, power toggles and rare clears woven in
		send_action(ACT_START);
		ticks_left = FULL_SCAN_TICKS;
		while (ticks_left > 0) begin
			r = $urandom_range(0, 99);
			if (r < 18) begin
				send_pixel_in_panel();
			end else if (r < 20) begin
				send_action(ACT_POWER);
			end else if ($urandom_range(0, 499) == 0) begin
				send_action(ACT_CLEAR);
			end else begin
				send_action(ACT_TICK);
				ticks_left--;
			end
		end
		repeat (10) send_action(ACT_TICK);

		s_axis_tvalid <= 1'b0;
		while (writes_pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Run covered %0d input transfers and %0d panel writes (%0d pixel updates).",
			items_sent, writes_seen, pixels_drawn);
		$display("Full refreshes completed: %0d, one long output stall included.",
			refreshes_done);
		if (mismatches == 0)
			$display("dual_chip_glcd_framebuffer_tb: done, clean");
		else
			$display("dual_chip_glcd_framebuffer_tb: done, errors");
		$finish;
	end

endmodule
